// ----- sv/bls_pkg.sv -----
// shared constants and types for the line pixel stepper
`default_nettype none

package bls_pkg;

    // default frame size in pixels
    localparam int FRAME_WIDTH_DEF  = 1024;
    localparam int FRAME_HEIGHT_DEF = 1024;

    // field widths
    localparam int COORD_W = 16;
    localparam int DELTA_W = 17;
    localparam int ADDR_W  = 22;
    localparam int COLOR_W = 24;
    localparam int BYTE_W  = 8;

    // color after reset: white
    localparam logic [COLOR_W-1:0] COLOR_RESET = 24'hFFFFFF;

    // item mode codes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_STEP  = 1'b1;

    // frame check result for one pixel
    typedef struct packed {
        logic              visible;
        logic [ADDR_W-1:0] addr;
    } bls_pix_t;

endpackage

`default_nettype wire

// ----- sv/bls_pixel_addr.sv -----
// frame clip test and framebuffer byte address for one pixel
`default_nettype none

module bls_pixel_addr #(
    parameter int FRAME_WIDTH  = bls_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = bls_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic signed [bls_pkg::COORD_W-1:0] px,
    input  wire logic signed [bls_pkg::COORD_W-1:0] py,
    output bls_pkg::bls_pix_t                       pix
);
    import bls_pkg::*;

    // two address bits below the pixel index select the byte of a 4-byte pixel
    localparam int LIN_W = ADDR_W - 2;

    logic        x_in;
    logic        y_in;
    logic [31:0] lin;

    // clip against the frame, negative coordinates are outside
    assign x_in = !px[COORD_W-1]
                  && ({1'b0, px[COORD_W-2:0]} < COORD_W'(FRAME_WIDTH));
    assign y_in = !py[COORD_W-1]
                  && ({1'b0, py[COORD_W-2:0]} < COORD_W'(FRAME_HEIGHT));

    // linear pixel index y*width + x
    assign lin = 32'(py[COORD_W-2:0]) * 32'(FRAME_WIDTH) + 32'(px[COORD_W-2:0]);

    always_comb
    begin
        pix.visible = x_in && y_in;
        pix.addr    = pix.visible ? {lin[LIN_W-1:0], 2'b00} : '0;
    end

endmodule

`default_nettype wire

// ----- sv/bresenham_line_pixel_stepper.sv -----
// Bresenham line stepper: start and step items in, one pixel result per item
// Latency: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; in_ready is high whenever the result
//   register is empty or its result is taken in the same cycle.
// The path per item is one delta add/compare and one address multiply.
// Reset (rst_n low, asynchronous) drops any line, empties the result
//   register and sets draw color to white.
`default_nettype none

module bresenham_line_pixel_stepper #(
    parameter int FRAME_WIDTH  = bls_pkg::FRAME_WIDTH_DEF,
    parameter int FRAME_HEIGHT = bls_pkg::FRAME_HEIGHT_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // configuration write
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [bls_pkg::COLOR_W-1:0]         cfg_data,
    // input items
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic signed [bls_pkg::COORD_W-1:0]  x_start,
    input  wire logic signed [bls_pkg::COORD_W-1:0]  y_start,
    input  wire logic signed [bls_pkg::COORD_W-1:0]  x_end,
    input  wire logic signed [bls_pkg::COORD_W-1:0]  y_end,
    // result items
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic                                     pixel_valid,
    output logic signed [bls_pkg::COORD_W-1:0]       pixel_x,
    output logic signed [bls_pkg::COORD_W-1:0]       pixel_y,
    output logic                                     inside_frame,
    output logic [bls_pkg::ADDR_W-1:0]               byte_address,
    output logic [bls_pkg::BYTE_W-1:0]               red,
    output logic [bls_pkg::BYTE_W-1:0]               green,
    output logic [bls_pkg::BYTE_W-1:0]               blue,
    output logic                                     last_pixel
);
    import bls_pkg::*;

    // line state
    logic [COLOR_W-1:0] color_reg;
    logic [COORD_W-1:0] cur_x_reg,      cur_x_next;
    logic [COORD_W-1:0] cur_y_reg,      cur_y_next;
    logic [DELTA_W-1:0] err_reg,        err_next;
    logic [DELTA_W-1:0] d_major_reg,    d_major_next;
    logic [DELTA_W-1:0] d_minor_reg,    d_minor_next;
    logic [DELTA_W-1:0] steps_reg,      steps_next;
    logic               x_neg_reg,      x_neg_next;
    logic               y_neg_reg,      y_neg_next;
    logic               x_major_reg,    x_major_next;
    logic               active_reg,     active_next;

    // result register
    logic               out_valid_reg;
    logic               res_pv;
    logic               res_last;
    logic               pv_reg;
    logic               last_reg;
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    logic               inside_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] rgb_reg;

    // datapath
    logic               in_fire;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
    logic [DELTA_W-1:0] adx;
    logic [DELTA_W-1:0] ady;
    logic               x_major_new;
    logic [DELTA_W:0]   e_sum;
    logic               minor_move;
    logic [DELTA_W-1:0] steps_dec;
    bls_pix_t           pix;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    // endpoint deltas and their magnitudes
    assign dx  = {x_end[COORD_W-1], x_end} - {x_start[COORD_W-1], x_start};
    assign dy  = {y_end[COORD_W-1], y_end} - {y_start[COORD_W-1], y_start};
    assign adx = dx[DELTA_W-1] ? (~dx + 1'b1) : dx;
    assign ady = dy[DELTA_W-1] ? (~dy + 1'b1) : dy;
    assign x_major_new = adx > ady;

    // error update for a step
    assign e_sum      = {1'b0, err_reg} + {1'b0, d_minor_reg};
    assign minor_move = e_sum >= {1'b0, d_major_reg};
    assign steps_dec  = steps_reg - 1'b1;

    // next state and the pixel this item gives
    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        err_next     = err_reg;
        d_major_next = d_major_reg;
        d_minor_next = d_minor_reg;
        steps_next   = steps_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_major_next = x_major_reg;
        active_next  = active_reg;
        res_pv       = 1'b0;
        res_last     = 1'b0;
        if (mode == MODE_START)
        begin
            cur_x_next   = x_start;
            cur_y_next   = y_start;
            x_neg_next   = dx[DELTA_W-1] || (dx == '0);
            y_neg_next   = dy[DELTA_W-1] || (dy == '0);
            x_major_next = x_major_new;
            d_major_next = x_major_new ? adx : ady;
            d_minor_next = x_major_new ? ady : adx;
            err_next     = d_major_next >> 1;
            steps_next   = d_major_next;
            active_next  = d_major_next != '0;
            res_pv       = 1'b1;
            res_last     = !active_next;
        end
        else if (active_reg)
        begin
            err_next = minor_move ? DELTA_W'(e_sum - {1'b0, d_major_reg})
                                  : DELTA_W'(e_sum);
            // major axis always moves, minor axis on error overflow
            if (x_major_reg || minor_move)
            begin
                cur_x_next = x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
            end
            if (!x_major_reg || minor_move)
            begin
                cur_y_next = y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
            end
            steps_next  = steps_dec;
            active_next = steps_dec != '0;
            res_pv      = 1'b1;
            res_last    = steps_dec == '0;
        end
    end

    // clip and address of the new pixel
    bls_pixel_addr #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_pix (
        .px  (cur_x_next),
        .py  (cur_y_next),
        .pix (pix)
    );

    // control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg     <= COLOR_RESET;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            err_reg       <= '0;
            d_major_reg   <= '0;
            d_minor_reg   <= '0;
            steps_reg     <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            x_major_reg   <= 1'b0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                color_reg <= cfg_data;
            end
            if (in_fire)
            begin
                cur_x_reg   <= cur_x_next;
                cur_y_reg   <= cur_y_next;
                err_reg     <= err_next;
                d_major_reg <= d_major_next;
                d_minor_reg <= d_minor_next;
                steps_reg   <= steps_next;
                x_neg_reg   <= x_neg_next;
                y_neg_reg   <= y_neg_next;
                x_major_reg <= x_major_next;
                active_reg  <= active_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, all zero when no pixel is given
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pv_reg     <= res_pv;
            last_reg   <= res_last;
            px_reg     <= res_pv ? cur_x_next : '0;
            py_reg     <= res_pv ? cur_y_next : '0;
            inside_reg <= res_pv && pix.visible;
            addr_reg   <= res_pv ? pix.addr : '0;
            rgb_reg    <= res_pv ? color_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_valid  = pv_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign inside_frame = inside_reg;
    assign byte_address = addr_reg;
    assign red          = rgb_reg[23:16];
    assign green        = rgb_reg[15:8];
    assign blue         = rgb_reg[7:0];
    assign last_pixel   = last_reg;

endmodule

`default_nettype wire

// ----- sv/bls_checker.sv -----
// port-level checks for the line pixel stepper, bound to the top level
`default_nettype none

module bls_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic                                pixel_valid,
    input wire logic signed [bls_pkg::COORD_W-1:0]  pixel_x,
    input wire logic signed [bls_pkg::COORD_W-1:0]  pixel_y,
    input wire logic                                inside_frame,
    input wire logic [bls_pkg::ADDR_W-1:0]          byte_address,
    input wire logic [bls_pkg::BYTE_W-1:0]          red,
    input wire logic [bls_pkg::BYTE_W-1:0]          green,
    input wire logic [bls_pkg::BYTE_W-1:0]          blue,
    input wire logic                                last_pixel
);
    import bls_pkg::*;

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x)
            && $stable(pixel_y) && $stable(byte_address) && $stable(last_pixel))
        else $error("result changed while stalled");

    // every accepted item gives a result in the next cycle
    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted item gave no result");

    // an empty result register never blocks the input
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // a result without a pixel carries all zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> pixel_x == '0 && pixel_y == '0
            && !inside_frame && byte_address == '0 && red == '0
            && green == '0 && blue == '0 && !last_pixel)
        else $error("empty result with nonzero fields");

    // pixels outside the frame get no address
    a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_frame |-> byte_address == '0)
        else $error("address given for clipped pixel");

endmodule

bind bresenham_line_pixel_stepper bls_checker u_bls_checker (.*);

`default_nettype wire

// ----- verif/tb_bresenham_line_pixel_stepper.sv -----
// testbench for the bresenham line pixel stepper: directed table, random lines, color changes
`timescale 1ns / 1ps

module tb_bresenham_line_pixel_stepper;

    import bls_pkg::*;

    localparam int FRAME_W    = FRAME_WIDTH_DEF;
    localparam int FRAME_H    = FRAME_HEIGHT_DEF;
    localparam int N_DIRECTED = 25;
    localparam int N_PHASES   = 5;
    localparam int PHASE_LEN  = 130;

    // one input item
    typedef struct packed {
        logic                      mode;
        logic signed [COORD_W-1:0] xs;
        logic signed [COORD_W-1:0] ys;
        logic signed [COORD_W-1:0] xe;
        logic signed [COORD_W-1:0] ye;
    } line_item_t;

    // one result item
    typedef struct packed {
        logic                      pix_valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      in_frame;
        logic [ADDR_W-1:0]         addr;
        logic [BYTE_W-1:0]         r;
        logic [BYTE_W-1:0]         g;
        logic [BYTE_W-1:0]         b;
        logic                      last;
    } pixel_result_t;

    // directed row: item plus an optional hand-written result
    typedef struct packed {
        line_item_t    item;
        logic          typed;
        pixel_result_t want;
    } stim_row_t;

    localparam pixel_result_t NO_PIXEL = '0;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [COLOR_W-1:0]        cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      mode = MODE_START;
    logic signed [COORD_W-1:0] x_start = '0;
    logic signed [COORD_W-1:0] y_start = '0;
    logic signed [COORD_W-1:0] x_end = '0;
    logic signed [COORD_W-1:0] y_end = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      pixel_valid;
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic                      inside_frame;
    logic [ADDR_W-1:0]         byte_address;
    logic [BYTE_W-1:0]         red;
    logic [BYTE_W-1:0]         green;
    logic [BYTE_W-1:0]         blue;
    logic                      last_pixel;

    bresenham_line_pixel_stepper #(
        .FRAME_WIDTH  (FRAME_W),
        .FRAME_HEIGHT (FRAME_H)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_valid  (pixel_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .inside_frame (inside_frame),
        .byte_address (byte_address),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .last_pixel   (last_pixel)
    );

    // clock
    always #6 clk = ~clk;

    // run limit
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // line stepper state as the testbench sees it
    logic signed [COORD_W-1:0] line_x;
    logic signed [COORD_W-1:0] line_y;
    logic [DELTA_W-1:0]        err_acc;
    logic [DELTA_W-1:0]        major_len;
    logic [DELTA_W-1:0]        minor_len;
    logic [DELTA_W-1:0]        pixels_left;
    logic                      x_back;
    logic                      y_back;
    logic                      x_leads;
    logic                      line_on;
    logic [COLOR_W-1:0]        paint_color;

    pixel_result_t pending_pixels[$];
    int            mismatches;
    int            items_sent;
    int            starts_sent;
    int            results_checked;
    int            colors_written;
    logic          idles_on;
    logic          stalls_on;

    // pixel at the current position, with frame check and address
    function automatic pixel_result_t current_pixel(logic last);
        pixel_result_t p;
        int            a;
        p           = '0;
        p.pix_valid = 1'b1;
        p.x         = line_x;
        p.y         = line_y;
        p.in_frame  = line_x >= 0 && line_x < FRAME_W && line_y >= 0 && line_y < FRAME_H;
        a           = (int'(line_y) * FRAME_W + int'(line_x)) * 4;
        p.addr      = p.in_frame ? a[ADDR_W-1:0] : '0;
        p.r         = paint_color[23:16];
        p.g         = paint_color[15:8];
        p.b         = paint_color[7:0];
        p.last      = last;
        return p;
    endfunction

    // advance the line by one item and give the pixel it yields
    function automatic pixel_result_t advance_stepper(line_item_t it);
        int                 dx;
        int                 dy;
        int                 adx;
        int                 ady;
        int                 major;
        int                 minor;
        logic [DELTA_W:0]   sum;
        logic               minor_move;
        if (it.mode == MODE_START)
        begin
            dx          = int'(it.xe) - int'(it.xs);
            dy          = int'(it.ye) - int'(it.ys);
            adx         = dx < 0 ? -dx : dx;
            ady         = dy < 0 ? -dy : dy;
            line_x      = it.xs;
            line_y      = it.ys;
            x_back      = !(dx > 0);
            y_back      = !(dy > 0);
            x_leads     = adx > ady;
            major       = x_leads ? adx : ady;
            minor       = x_leads ? ady : adx;
            major_len   = major[DELTA_W-1:0];
            minor_len   = minor[DELTA_W-1:0];
            err_acc     = major_len >> 1;
            pixels_left = major_len;
            line_on     = major_len != 0;
            return current_pixel(!line_on);
        end
        if (!line_on)
            return NO_PIXEL;
        sum        = {1'b0, err_acc} + {1'b0, minor_len};
        minor_move = sum >= {1'b0, major_len};
        if (minor_move)
            sum = sum - {1'b0, major_len};
        err_acc = sum[DELTA_W-1:0];
        if (x_leads)
        begin
            if (minor_move)
                line_y = y_back ? line_y - 16'sd1 : line_y + 16'sd1;
            line_x = x_back ? line_x - 16'sd1 : line_x + 16'sd1;
        end
        else
        begin
            if (minor_move)
                line_x = x_back ? line_x - 16'sd1 : line_x + 16'sd1;
            line_y = y_back ? line_y - 16'sd1 : line_y + 16'sd1;
        end
        pixels_left = pixels_left - 1'b1;
        if (pixels_left == 0)
            line_on = 1'b0;
        return current_pixel(pixels_left == 0);
    endfunction

    // idle or stall length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic stim_row_t mk(logic m, int xs, int ys, int xe, int ye,
                                     logic typed, pixel_result_t want);
        stim_row_t row;
        row.item.mode = m;
        row.item.xs   = 16'(xs);
        row.item.ys   = 16'(ys);
        row.item.xe   = 16'(xe);
        row.item.ye   = 16'(ye);
        row.typed     = typed;
        row.want      = want;
        return row;
    endfunction

    // single-point line in the reset color
    function automatic pixel_result_t lone_pixel(int x, int y, logic in_frame, int addr);
        pixel_result_t p;
        p.pix_valid = 1'b1;
        p.x         = 16'(x);
        p.y         = 16'(y);
        p.in_frame  = in_frame;
        p.addr      = 22'(addr);
        p.r         = 8'hFF;
        p.g         = 8'hFF;
        p.b         = 8'hFF;
        p.last      = 1'b1;
        return p;
    endfunction

    function automatic line_item_t step_item();
        line_item_t it;
        it.mode = MODE_STEP;
        it.xs   = 16'($urandom());
        it.ys   = 16'($urandom());
        it.xe   = 16'($urandom());
        it.ye   = 16'($urandom());
        return it;
    endfunction

    // drive one item from a falling edge, wait for acceptance, record its result
    task automatic send_item(line_item_t it, logic typed, pixel_result_t want);
        int            gap;
        pixel_result_t got;
        gap = (idles_on && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        mode     = it.mode;
        x_start  = it.xs;
        y_start  = it.ys;
        x_end    = it.xe;
        y_end    = it.ye;
        in_valid = 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = advance_stepper(it);
        pending_pixels.push_back(typed ? want : got);
        items_sent++;
        if (it.mode == MODE_START)
            starts_sent++;
        @(negedge clk);
    endtask

    // wait at a falling edge until every expected pixel has come back
    task automatic wait_drained();
        in_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // color write while the block is idle
    task automatic write_color(logic [COLOR_W-1:0] c);
        wait_drained();
        cfg_data  = c;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        paint_color = c;
        colors_written++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // random lines: mostly whole lines, some abandoned or overrun, some noise
    task automatic run_random(int n);
        int         count;
        int         r;
        int         len;
        int         side;
        int         dx;
        int         dy;
        int         xs;
        int         ys;
        int         plan;
        int         k;
        line_item_t it;
        count = 0;
        while (count < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                r = $urandom_range(0, 99);
                len  = r < 85 ? $urandom_range(0, 12)
                     : r < 97 ? $urandom_range(13, 60) : $urandom_range(61, 300);
                side = $urandom_range(0, len);
                if ($urandom_range(0, 1))
                begin
                    dx = len;
                    dy = side;
                end
                else
                begin
                    dx = side;
                    dy = len;
                end
                if ($urandom_range(0, 1))
                    dx = -dx;
                if ($urandom_range(0, 1))
                    dy = -dy;
                if ($urandom_range(0, 1))
                begin
                    xs = $urandom_range(0, FRAME_W + 39) - 20;
                    ys = $urandom_range(0, FRAME_H + 39) - 20;
                end
                else
                begin
                    xs = $urandom_range(0, 65535) - 32768;
                    ys = $urandom_range(0, 65535) - 32768;
                end
                if (xs + dx > 32767 || xs + dx < -32768)
                    dx = -dx;
                if (ys + dy > 32767 || ys + dy < -32768)
                    dy = -dy;
                r = $urandom_range(0, 99);
                plan = len;
                if (r < 15 && len > 1)
                    plan = $urandom_range(1, len - 1);
                else if (r < 25)
                    plan = len + $urandom_range(1, 2);
                it.mode = MODE_START;
                it.xs   = 16'(xs);
                it.ys   = 16'(ys);
                it.xe   = 16'(xs + dx);
                it.ye   = 16'(ys + dy);
                send_item(it, 1'b0, NO_PIXEL);
                for (k = 0; k < plan; k++)
                    send_item(step_item(), 1'b0, NO_PIXEL);
                count += plan + 1;
            end
            else if (r < 85)
            begin
                // endpoints anywhere in the coordinate range, walked a little
                it      = step_item();
                it.mode = MODE_START;
                send_item(it, 1'b0, NO_PIXEL);
                plan = $urandom_range(0, 4);
                for (k = 0; k < plan; k++)
                    send_item(step_item(), 1'b0, NO_PIXEL);
                count += plan + 1;
            end
            else
            begin
                send_item(step_item(), 1'b0, NO_PIXEL);
                count++;
            end
        end
    endtask

    // result channel stalls
    initial
    begin : drive_out_ready
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                out_ready  = 1'b0;
                stall_left = idle_len() - 1;
            end
            else
                out_ready = 1'b1;
        end
    end

    task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, seen);
            mismatches++;
        end
    endtask

    // compare each accepted pixel with the oldest expectation
    always @(posedge clk)
    begin : check_pixels
        pixel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t ns: pixel (%0d, %0d) arrived with nothing expected",
                         $time, pixel_x, pixel_y);
                mismatches++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("pixel_valid",  32'(want.pix_valid), 32'(pixel_valid));
                check_field("pixel_x",      32'(want.x),         32'(pixel_x));
                check_field("pixel_y",      32'(want.y),         32'(pixel_y));
                check_field("inside_frame", 32'(want.in_frame),  32'(inside_frame));
                check_field("byte_address", 32'(want.addr),      32'(byte_address));
                check_field("red",          32'(want.r),         32'(red));
                check_field("green",        32'(want.g),         32'(green));
                check_field("blue",         32'(want.b),         32'(blue));
                check_field("last_pixel",   32'(want.last),      32'(last_pixel));
                results_checked++;
            end
        end
    end

    // main sequence
    initial
    begin : main_flow
        stim_row_t          directed [N_DIRECTED];
        logic [COLOR_W-1:0] phase_color [N_PHASES];
        int                 i;

        mismatches      = 0;
        items_sent      = 0;
        starts_sent     = 0;
        results_checked = 0;
        colors_written  = 0;
        idles_on        = 1'b1;
        stalls_on       = 1'b1;
        line_x          = '0;
        line_y          = '0;
        err_acc         = '0;
        major_len       = '0;
        minor_len       = '0;
        pixels_left     = '0;
        x_back          = 1'b0;
        y_back          = 1'b0;
        x_leads         = 1'b0;
        line_on         = 1'b0;
        paint_color     = COLOR_RESET;

        directed = '{
            // step with no line after reset
            mk(MODE_STEP,  0, 0, 0, 0, 1'b1, NO_PIXEL),
            // single points: origin, far frame corner, range extremes, just outside
            mk(MODE_START, 0, 0, 0, 0, 1'b1, lone_pixel(0, 0, 1'b1, 0)),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b1, NO_PIXEL),
            mk(MODE_START, 1023, 1023, 1023, 1023, 1'b1,
               lone_pixel(1023, 1023, 1'b1, 22'h3FFFFC)),
            mk(MODE_START, -32768, -32768, -32768, -32768, 1'b1,
               lone_pixel(-32768, -32768, 1'b0, 0)),
            mk(MODE_START, 32767, 32767, 32767, 32767, 1'b1,
               lone_pixel(32767, 32767, 1'b0, 0)),
            mk(MODE_START, 1024, 0, 1024, 0, 1'b1, lone_pixel(1024, 0, 1'b0, 0)),
            mk(MODE_START, 0, 1024, 0, 1024, 1'b1, lone_pixel(0, 1024, 1'b0, 0)),
            // shallow x-major line walked to its end, then one step too many
            mk(MODE_START, 0, 0, 3, 1, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b1, NO_PIXEL),
            // equal deltas going down-left, dropped by a new start
            mk(MODE_START, 5, 5, 2, 2, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  -1, -1, -1, -1, 1'b0, NO_PIXEL),
            // horizontal line, zero dy
            mk(MODE_START, 10, 0, 7, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            // full-range diagonal, largest deltas
            mk(MODE_START, -32768, 32767, 32767, -32768, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            // line crossing the frame corner
            mk(MODE_START, 1020, 1023, 1027, 1020, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL),
            mk(MODE_STEP,  0, 0, 0, 0, 1'b0, NO_PIXEL)
        };

        phase_color[0] = 24'h000000;
        phase_color[1] = 24'hFFFFFF;
        phase_color[2] = 24'($urandom());
        phase_color[3] = 24'h0F5AA5;
        phase_color[4] = 24'($urandom());

        // reset
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table in the reset color
        for (i = 0; i < N_DIRECTED; i++)
            send_item(directed[i].item, directed[i].typed, directed[i].want);

        // random phases, one color each; the first runs with no idling at all
        for (i = 0; i < N_PHASES; i++)
        begin
            write_color(phase_color[i]);
            idles_on  = i != 0;
            stalls_on = i != 0;
            run_random(PHASE_LEN);
        end
        idles_on  = 1'b0;
        stalls_on = 1'b0;
        wait_drained();

        $display("%0d items sent (%0d line starts), %0d pixels checked, %0d colors used",
                 items_sent, starts_sent, results_checked, colors_written);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/bls_pkg.sv
sv/bls_pixel_addr.sv
sv/bresenham_line_pixel_stepper.sv
sv/bls_checker.sv
verif/tb_bresenham_line_pixel_stepper.sv
